@@ rtl/pfb_pkg.sv @@
// shared types and constants for the page frame buffer drawer
`default_nettype none

package pfb_pkg;

	// pixel bits per store byte, and coordinate width inside the rasterizer
	localparam int BYTE_W  = 8;
	localparam int COORD_W = 10;

	// request codes of the command word
	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_RECT  = 2'd1,
		REQ_DISC  = 2'd2,
		REQ_READ  = 2'd3
	} req_kind_t;

	// control sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_RECT,
		ST_DISC,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	// the four spans of a rectangle outline
	typedef enum logic [1:0] {
		PH_TOP    = 2'd0,
		PH_BOTTOM = 2'd1,
		PH_LEFT   = 2'd2,
		PH_RIGHT  = 2'd3
	} rect_phase_t;

endpackage

`default_nettype wire

@@ rtl/page_framebuffer_rect_circle_drawer_unit.sv @@
// page organized monochrome frame buffer with rectangle outline and filled disc drawing
// a read passes a read state, a clear sweeps every store byte, a rectangle walks its top,
// bottom, left and right spans (a reversed pair of spans is empty), a disc scans every
// offset of its square of side 2*r+1; one pixel read-modify-write per cycle through the store port
// one command at a time: next word taken the cycle after done, done cannot be held off
// after reset the store is swept to zero, all SCREEN_COLUMNS*PAGE_COUNT bytes, with busy high
`default_nettype none

module page_framebuffer_rect_circle_drawer_unit
	import pfb_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 72,
	parameter int PAGE_COUNT     = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        req_type,
	input  wire logic signed [7:0] first_x,
	input  wire logic signed [7:0] first_y,
	input  wire logic signed [7:0] second_x,
	input  wire logic signed [7:0] second_y,
	input  wire logic [3:0]        disc_radius,
	input  wire logic [2:0]        read_page,
	input  wire logic [6:0]        read_column,
	output logic                   busy,
	output logic                   done,
	output logic [7:0]             read_data,
	output logic [1:0]             command_kind
);

	localparam int DEPTH = SCREEN_COLUMNS * PAGE_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(SCREEN_COLUMNS);
	localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int ROWS  = PAGE_COUNT * 8;

	state_t state_q, state_d;

	// latched command
	req_kind_t         kind_q;
	logic signed [7:0] xa_q, ya_q, xb_q, yb_q;
	logic [3:0]        rad_q;
	logic [7:0]        rr_q;
	logic [AW-1:0]     rd_addr_q;
	logic              rd_ok_q;

	// rasterizer position
	rect_phase_t       phase_q;
	logic signed [8:0] i_q;
	logic signed [4:0] u_q, v_q;

	// clear sweep
	logic [AW-1:0] clr_q;
	logic          clr_last;

	// write stage and forwarding
	logic              wr_en_s1;
	logic [AW-1:0]     addr_s1;
	logic [BYTE_W-1:0] mask_s1;
	logic              fwd_vld_q;
	logic [AW-1:0]     fwd_addr_q;
	logic [BYTE_W-1:0] fwd_data_q;
	logic [BYTE_W-1:0] wdata_s1;

	// sequencer outputs
	logic sweep_we, gen_run;

	logic accept;
	assign accept = start && !busy;

	// ---------------------------------------------------------------------
	// rectangle span stepping
	logic signed [7:0]         span_lo, span_hi, next_lo;
	logic                      rect_empty, rect_at_end, rect_last;
	logic signed [COORD_W-1:0] rect_x, rect_y;
	logic signed [COORD_W-1:0] i_ext;

	assign i_ext = {i_q[8], i_q};

	always_comb begin
		span_lo = xa_q;
		span_hi = xb_q;
		next_lo = xa_q;
		rect_x  = i_ext;
		rect_y  = {{2{ya_q[7]}}, ya_q};
		case (phase_q)
			PH_TOP: begin
				span_lo = xa_q;
				span_hi = xb_q;
				next_lo = xa_q;
				rect_x  = i_ext;
				rect_y  = {{2{ya_q[7]}}, ya_q};
			end
			PH_BOTTOM: begin
				span_lo = xa_q;
				span_hi = xb_q;
				next_lo = ya_q;
				rect_x  = i_ext;
				rect_y  = {{2{yb_q[7]}}, yb_q};
			end
			PH_LEFT: begin
				span_lo = ya_q;
				span_hi = yb_q;
				next_lo = ya_q;
				rect_x  = {{2{xa_q[7]}}, xa_q};
				rect_y  = i_ext;
			end
			PH_RIGHT: begin
				span_lo = ya_q;
				span_hi = yb_q;
				next_lo = ya_q;
				rect_x  = {{2{xb_q[7]}}, xb_q};
				rect_y  = i_ext;
			end
			default: begin
				span_lo = xa_q;
				span_hi = xb_q;
				next_lo = xa_q;
			end
		endcase
		rect_empty  = span_lo > span_hi;
		rect_at_end = rect_empty || (i_q == {span_hi[7], span_hi});
		rect_last   = rect_at_end && (phase_q == PH_RIGHT);
	end

	// ---------------------------------------------------------------------
	// disc offset test
	logic [3:0]                abs_u, abs_v;
	logic [8:0]                dist_sq;
	logic                      disc_in, disc_last;
	logic signed [4:0]         r_pos;
	logic signed [COORD_W-1:0] disc_x, disc_y;

	assign abs_u     = u_q[4] ? 4'(-u_q) : u_q[3:0];
	assign abs_v     = v_q[4] ? 4'(-v_q) : v_q[3:0];
	assign dist_sq   = 9'(abs_u * abs_u) + 9'(abs_v * abs_v);
	assign disc_in   = dist_sq <= {1'b0, rr_q};
	assign r_pos     = {1'b0, rad_q};
	assign disc_last = (u_q == r_pos) && (v_q == r_pos);
	assign disc_x    = {{2{xa_q[7]}}, xa_q} + {{5{u_q[4]}}, u_q};
	assign disc_y    = {{2{ya_q[7]}}, ya_q} + {{5{v_q[4]}}, v_q};

	// ---------------------------------------------------------------------
	// pixel select, clip and byte address
	logic signed [COORD_W-1:0] gen_x, gen_y;
	logic                      gen_emit, gen_last, pix_ok;
	logic [PW-1:0]             pix_page;
	logic [AW-1:0]             pix_addr;
	logic [BYTE_W-1:0]         pix_mask;

	always_comb begin
		if (state_q == ST_RECT) begin
			gen_x    = rect_x;
			gen_y    = rect_y;
			gen_emit = !rect_empty;
			gen_last = rect_last;
		end else begin
			gen_x    = disc_x;
			gen_y    = disc_y;
			gen_emit = disc_in;
			gen_last = disc_last;
		end
	end

	assign pix_ok = gen_run && gen_emit
		&& !gen_x[COORD_W-1] && (gen_x[COORD_W-2:0] < 9'(SCREEN_COLUMNS))
		&& !gen_y[COORD_W-1] && (gen_y[COORD_W-2:0] < 9'(ROWS));
	assign pix_page = gen_y[3 +: PW];
	assign pix_addr = AW'(pix_page) * AW'(SCREEN_COLUMNS) + AW'(gen_x[CW-1:0]);
	assign pix_mask = BYTE_W'(1) << gen_y[2:0];

	// ---------------------------------------------------------------------
	// frame store
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	assign ram_we    = sweep_we || wr_en_s1;
	assign ram_waddr = sweep_we ? clr_q : addr_s1;
	assign ram_wdata = sweep_we ? '0 : wdata_s1;
	assign ram_raddr = (state_q == ST_READ) ? rd_addr_q : pix_addr;

	pfb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// merge pixel into the byte, forwarding the write of the cycle before
	assign wdata_s1 = ((fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata)
		| mask_s1;

	// ---------------------------------------------------------------------
	// sequencer next state
	assign clr_last = clr_q == AW'(DEPTH - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					case (req_kind_t'(req_type))
						REQ_CLEAR: state_d = ST_CLEAR;
						REQ_RECT:  state_d = ST_RECT;
						REQ_DISC:  state_d = ST_DISC;
						REQ_READ:  state_d = ST_READ;
						default:   state_d = ST_READ;
					endcase
				end
			end
			ST_CLEAR: if (clr_last) state_d = ST_DONE;
			ST_RECT:  if (rect_last) state_d = ST_DRAIN;
			ST_DISC:  if (disc_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy     = state_q != ST_IDLE;
		done     = state_q == ST_DONE;
		sweep_we = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		gen_run  = (state_q == ST_RECT) || (state_q == ST_DISC);
	end

	// result word
	assign command_kind = kind_q;
	assign read_data    = (done && (kind_q == REQ_READ) && rd_ok_q) ? ram_rdata : '0;

	// ---------------------------------------------------------------------
	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			clr_q     <= '0;
			wr_en_s1  <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			wr_en_s1  <= pix_ok;
			fwd_vld_q <= wr_en_s1;
			if (sweep_we) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
			end
		end
	end

	// command latch and write stage payload
	always_ff @(posedge clk) begin
		addr_s1    <= pix_addr;
		mask_s1    <= pix_mask;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= wdata_s1;
		if (accept) begin
			kind_q    <= req_kind_t'(req_type);
			xa_q      <= first_x;
			ya_q      <= first_y;
			xb_q      <= second_x;
			yb_q      <= second_y;
			rad_q     <= disc_radius;
			rr_q      <= 8'(disc_radius * disc_radius);
			rd_addr_q <= AW'(read_page) * AW'(SCREEN_COLUMNS) + AW'(read_column);
			rd_ok_q   <= (32'(read_page) < PAGE_COUNT) && (32'(read_column) < SCREEN_COLUMNS);
		end
	end

	// rasterizer position
	always_ff @(posedge clk) begin
		if (accept) begin
			phase_q <= PH_TOP;
			i_q     <= {first_x[7], first_x};
			u_q     <= 5'(-$signed({1'b0, disc_radius}));
			v_q     <= 5'(-$signed({1'b0, disc_radius}));
		end else if (state_q == ST_RECT) begin
			if (rect_at_end) begin
				phase_q <= rect_phase_t'(phase_q + 2'd1);
				i_q     <= {next_lo[7], next_lo};
			end else begin
				i_q <= i_q + 9'sd1;
			end
		end else if (state_q == ST_DISC) begin
			if (u_q == r_pos) begin
				u_q <= -r_pos;
				v_q <= v_q + 5'sd1;
			end else begin
				u_q <= u_q + 5'sd1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after done");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep_we && wr_en_s1))
		else $error("clear sweep and pixel write collide");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> (state_q == ST_RECT || state_q == ST_DISC || state_q == ST_DRAIN))
		else $error("pixel write outside drawing");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && command_kind != REQ_READ) |-> read_data == 8'd0)
		else $error("nonzero data on a non-read result");

endmodule

`default_nettype wire

@@ rtl/pfb_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none

module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 576
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ dv/pfb_draw_checker.sv @@
// watches the command and done channels, keeps a shadow frame store and compares each done word
module pfb_draw_checker
	import pfb_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 72,
	parameter int PAGE_COUNT     = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              done,
	input  logic [1:0]        req_type,
	input  logic signed [7:0] first_x,
	input  logic signed [7:0] first_y,
	input  logic signed [7:0] second_x,
	input  logic signed [7:0] second_y,
	input  logic [3:0]        disc_radius,
	input  logic [2:0]        read_page,
	input  logic [6:0]        read_column,
	input  logic [7:0]        read_data,
	input  logic [1:0]        command_kind,
	output int                mismatches,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN_ROWS = PAGE_COUNT * BYTE_W;

	typedef struct {
		logic [7:0] data;
		req_kind_t  kind;
	} done_word_t;

	// shadow of the frame store and the done words still to come
	logic [7:0] shadow_pages [SCREEN_COLUMNS * PAGE_COUNT];
	done_word_t awaited_words [$];

	// or one pixel into the shadow store, dropping anything off screen
	function automatic void plot_shadow(int x, int y);
		int idx;
		if (x >= 0 && x < SCREEN_COLUMNS && y >= 0 && y < SCREEN_ROWS) begin
			idx = (y / BYTE_W) * SCREEN_COLUMNS + x;
			shadow_pages[idx] = shadow_pages[idx] | (8'd1 << (y % BYTE_W));
		end
	endfunction

	// apply one command word to the shadow store and give its done word
	function automatic done_word_t draw_and_predict(logic [1:0] kind_bits, int fx, int fy,
			int sx, int sy, int rad, int pg, int col);
		done_word_t w;
		int u;
		int v;
		w.kind = req_kind_t'(kind_bits);
		w.data = '0;
		case (w.kind)
			REQ_CLEAR: begin
				foreach (shadow_pages[i]) shadow_pages[i] = '0;
			end
			REQ_RECT: begin
				// reversed bounds simply leave the matching spans empty
				for (u = fx; u <= sx; u++) begin
					plot_shadow(u, fy);
					plot_shadow(u, sy);
				end
				for (v = fy; v <= sy; v++) begin
					plot_shadow(fx, v);
					plot_shadow(sx, v);
				end
			end
			REQ_DISC: begin
				for (v = -rad; v <= rad; v++) begin
					for (u = -rad; u <= rad; u++) begin
						if (u * u + v * v <= rad * rad) plot_shadow(fx + u, fy + v);
					end
				end
			end
			default: begin
				if (pg < PAGE_COUNT && col < SCREEN_COLUMNS) begin
					w.data = shadow_pages[pg * SCREEN_COLUMNS + col];
				end
			end
		endcase
		return w;
	endfunction

	// done is retired before a word taken on the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		done_word_t head;
		if (!arst_n) begin
			foreach (shadow_pages[i]) shadow_pages[i] = '0;
			awaited_words.delete();
		end else begin
			if (done === 1'b1) begin
				if (awaited_words.size() == 0) begin
					mismatches++;
					$display("%0t: done word with none awaited, read_data 8'h%02h kind %0d",
						$time, read_data, command_kind);
				end else begin
					head = awaited_words.pop_front();
					if (read_data !== head.data) begin
						mismatches++;
						$display("%0t: read_data expected 8'h%02h actual 8'h%02h",
							$time, head.data, read_data);
					end
					if (command_kind !== head.kind) begin
						mismatches++;
						$display("%0t: command_kind expected %0d actual %0d",
							$time, head.kind, command_kind);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				awaited_words.push_back(draw_and_predict(req_type, int'(first_x),
					int'(first_y), int'(second_x), int'(second_y), int'(disc_radius),
					int'(read_page), int'(read_column)));
			end
		end
		pending = awaited_words.size();
	end

endmodule

@@ dv/tb.sv @@
// top of the frame buffer drawer testbench: clock, reset, command words and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pfb_pkg::*;

	localparam int SCREEN_COLUMNS = 72;
	localparam int PAGE_COUNT     = 8;
	localparam int PHASE_WORDS    = 384;
	localparam int DRAIN_LIMIT    = 20000;

	typedef struct {
		req_kind_t         kind;
		logic signed [7:0] fx;
		logic signed [7:0] fy;
		logic signed [7:0] sx;
		logic signed [7:0] sy;
		logic [3:0]        rad;
		logic [2:0]        pg;
		logic [6:0]        col;
	} draw_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        req_type = '0;
	logic signed [7:0] first_x = '0;
	logic signed [7:0] first_y = '0;
	logic signed [7:0] second_x = '0;
	logic signed [7:0] second_y = '0;
	logic [3:0]        disc_radius = '0;
	logic [2:0]        read_page = '0;
	logic [6:0]        read_column = '0;
	logic              busy;
	logic              done;
	logic [7:0]        read_data;
	logic [1:0]        command_kind;
	int                mismatches;
	int                pending;
	int                idle_pct = 34;

	page_framebuffer_rect_circle_drawer_unit #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.PAGE_COUNT(PAGE_COUNT)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
		.disc_radius(disc_radius), .read_page(read_page), .read_column(read_column),
		.busy(busy), .done(done), .read_data(read_data), .command_kind(command_kind)
	);

	pfb_draw_checker #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.PAGE_COUNT(PAGE_COUNT)
	) draw_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.req_type(req_type), .first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y), .disc_radius(disc_radius),
		.read_page(read_page), .read_column(read_column), .read_data(read_data),
		.command_kind(command_kind), .mismatches(mismatches), .pending(pending)
	);

	// 10 ns clock
	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop for a hung block
	initial begin
		#60_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic draw_word_t word_of(req_kind_t kind, int fx, int fy, int sx, int sy,
			int rad, int pg, int col);
		draw_word_t w;
		w.kind = kind;
		w.fx = 8'(fx);
		w.fy = 8'(fy);
		w.sx = 8'(sx);
		w.sy = 8'(sy);
		w.rad = 4'(rad);
		w.pg = 3'(pg);
		w.col = 7'(col);
		return w;
	endfunction

	// mostly small shapes near the screen, now and then anything at all
	function automatic draw_word_t random_word();
		draw_word_t w;
		int roll;
		int x0;
		int y0;
		roll = $urandom_range(99);
		w.fx = 8'($urandom);
		w.fy = 8'($urandom);
		w.sx = 8'($urandom);
		w.sy = 8'($urandom);
		w.rad = 4'($urandom);
		w.pg = 3'($urandom);
		w.col = 7'($urandom);
		if (roll < 4) begin
			w.kind = REQ_CLEAR;
		end else if (roll < 30) begin
			w.kind = REQ_RECT;
			if ($urandom_range(9) != 0) begin
				x0 = $urandom_range(92) - 12;
				y0 = $urandom_range(84) - 12;
				w.fx = 8'(x0);
				w.fy = 8'(y0);
				w.sx = 8'(x0 + $urandom_range(16) - 3);
				w.sy = 8'(y0 + $urandom_range(16) - 3);
			end
		end else if (roll < 55) begin
			w.kind = REQ_DISC;
			if ($urandom_range(9) != 0) begin
				w.fx = 8'($urandom_range(104) - 16);
				w.fy = 8'($urandom_range(96) - 16);
				w.rad = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
					4'($urandom_range(7));
			end
		end else begin
			w.kind = REQ_READ;
			w.col = ($urandom_range(6) == 0) ? 7'($urandom_range(127, 72)) :
				7'($urandom_range(71));
		end
		return w;
	endfunction

	// present one word after a random gap, return on the edge that takes it
	task automatic send_word(input draw_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req_type <= w.kind;
		first_x <= w.fx;
		first_y <= w.fy;
		second_x <= w.sx;
		second_y <= w.sy;
		disc_radius <= w.rad;
		read_page <= w.pg;
		read_column <= w.col;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// hold off until every done word has come back
	task automatic wait_drained();
		int spins;
		spins = 0;
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0 && spins < DRAIN_LIMIT) begin
			@(negedge clk);
			spins++;
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed words: full border, reversed and huge bounds, disc edges, bad reads
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		send_word(word_of(REQ_RECT, 0, 0, 71, 63, 0, 0, 0));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 7, 71));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 3, 71));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 0, 72));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 5, 127));
		send_word(word_of(REQ_CLEAR, -1, -1, -1, -1, 15, 7, 127));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		send_word(word_of(REQ_RECT, 20, 10, 5, 30, 0, 0, 0));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 2, 20));
		send_word(word_of(REQ_RECT, 5, 40, 30, 20, 0, 0, 0));
		send_word(word_of(REQ_RECT, 10, 10, 0, 0, 0, 0, 0));
		send_word(word_of(REQ_RECT, -128, -128, 127, 127, 0, 0, 0));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		send_word(word_of(REQ_DISC, 36, 32, 0, 0, 0, 0, 0));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 4, 36));
		send_word(word_of(REQ_DISC, -128, -128, 0, 0, 15, 0, 0));
		send_word(word_of(REQ_DISC, 127, 127, 0, 0, 15, 0, 0));
		send_word(word_of(REQ_DISC, 36, 32, 0, 0, 15, 0, 0));
		send_word(word_of(REQ_READ, -1, -128, 127, -1, 15, 4, 36));
		send_word(word_of(REQ_RECT, 68, 60, 80, 70, 0, 0, 0));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 7, 70));
		send_word(word_of(REQ_DISC, -3, -3, 0, 0, 5, 0, 0));
		send_word(word_of(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		wait_drained();

		// random words in three idling phases, with a full drain now and then
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 34 : (phase == 1) ? 72 : 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				send_word(random_word());
				if (n % 97 == 96) wait_drained();
			end
		end

		// let the last done words arrive, then a short tail
		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pfb_pkg.sv
rtl/pfb_ram.sv
rtl/page_framebuffer_rect_circle_drawer_unit.sv
dv/pfb_draw_checker.sv
dv/tb.sv
